// ----- rtl/wsm_pkg.sv -----
// Package for the word shape matcher: shared constants, types and the
// letter classifier. No dependencies.
package wsm_pkg;

  localparam int unsigned LETTER_COUNT = 52;
  localparam int unsigned LETTER_W     = 6;
  localparam int unsigned CODE_W       = 5;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned PLEN_W       = 5;
  localparam int unsigned CODES_W      = 40;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned PATTERN_MAX_DEF = 16;

  localparam logic [CODE_W-1:0] CODE_FIRST = 5'd1;
  localparam logic [CODE_W-1:0] CODE_LIMIT = 5'd31;
  localparam logic [POS_W-1:0]  POS_LIMIT  = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_CODES_LOW      = 2'd1,
    CFG_CODES_HIGH     = 2'd2
  } cfg_idx_e;

  // Classified input byte
  typedef struct packed {
    logic                is_letter;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // Pattern view handed from the config block to the datapath
  typedef struct packed {
    logic [PLEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } pat_view_t;

  // a-z map to 0..25, A-Z to 26..51
  function automatic letter_t letter_index(input logic [7:0] ch);
    letter_t r;
    r.is_letter = 1'b0;
    r.idx       = '0;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.is_letter = 1'b1;
      r.idx       = LETTER_W'(ch - 8'h61);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.is_letter = 1'b1;
      r.idx       = LETTER_W'(ch - 8'h41 + 8'd26);
    end
    return r;
  endfunction

endpackage

// ----- rtl/wsm_code_mem.sv -----
// Per-letter code store: one write port, one read port, registered read data.
// Depends on wsm_pkg.
module wsm_code_mem
  import wsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [LETTER_W-1:0] waddr_i,
  input  logic [CODE_W-1:0]   wdata_i,
  input  logic                re_i,
  input  logic [LETTER_W-1:0] raddr_i,
  output logic [CODE_W-1:0]   rdata_o
);

  logic [CODE_W-1:0] mem_q [LETTER_COUNT];
  logic [CODE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wsm_cfg_regs.sv -----
// Pattern configuration registers and per-position pattern code lookup.
// Depends on wsm_pkg.
module wsm_cfg_regs
  import wsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CODES_W-1:0]   cfg_data_i,
  input  logic [3:0]           pos_i,
  output pat_view_t            pat_o
);

  logic [PLEN_W-1:0]  plen_q;
  logic [CODES_W-1:0] codes_lo_q, codes_hi_q;
  logic [CODES_W-1:0] sel_word;

  assign cfg_ready_o = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q     <= '0;
      codes_lo_q <= '0;
      codes_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: plen_q     <= cfg_data_i[PLEN_W-1:0];
        CFG_CODES_LOW:      codes_lo_q <= cfg_data_i;
        CFG_CODES_HIGH:     codes_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // code of the requested position
  always_comb begin
    sel_word    = pos_i[3] ? codes_hi_q : codes_lo_q;
    pat_o.len   = plen_q;
    pat_o.code  = sel_word[pos_i[2:0]*CODE_W +: CODE_W];
  end

endmodule

// ----- rtl/word_shape_matcher.sv -----
// Word shape matcher top level: input stage, word state and result register.
// Depends on wsm_pkg, wsm_code_mem and wsm_cfg_regs.
//
// Takes one byte per cycle and returns one item per closed word (start offset,
// saturated length, shape match). A byte is accepted, its letter's code is read
// from the code memory at the accepting edge, and the byte is resolved in the
// following cycle; the result is then registered in the result register unless
// a held, untaken result stalls it. Sustained rate is one byte per cycle while
// results are taken; a read of a letter that the byte ahead writes at the same
// edge is served by forwarding. The per-letter seen flags are flip-flops, all
// cleared together when a word closes, so there is no clearing pass after reset
// or between words.
module word_shape_matcher
  import wsm_pkg::*;
#(
  parameter int unsigned PatternMax = PATTERN_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CODES_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           character_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 matched_o,
  output logic [OFFSET_W-1:0]  word_start_o,
  output logic [POS_W-1:0]     word_length_o
);

  localparam logic [PLEN_W-1:0] PatMaxLen = PLEN_W'(PatternMax);
  localparam logic [POS_W-1:0]  PatMaxPos = POS_W'(PatternMax);

  letter_t in_letter;
  logic    in_accept;

  // input stage
  logic                s1_valid_q, s1_valid_d;
  logic                s1_letter_q, s1_eoi_q;
  logic [LETTER_W-1:0] s1_idx_q;
  logic [OFFSET_W-1:0] s1_off_q;
  logic                s1_fwd_q;
  logic [CODE_W-1:0]   s1_fwd_code_q;

  // word state
  logic [LETTER_COUNT-1:0] seen_q, seen_d;
  logic [CODE_W-1:0]       next_code_q, next_code_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    mism_q, mism_d;
  logic                    in_word_q, in_word_d;
  logic [OFFSET_W-1:0]     start_q, start_d;
  logic [OFFSET_W-1:0]     offset_q;

  // result register
  logic                out_valid_q, out_valid_d;
  logic                out_matched_q;
  logic [OFFSET_W-1:0] out_start_q;
  logic [POS_W-1:0]    out_len_q;

  // datapath
  logic              go, close_w, seen_hit, in_range, bad, matched;
  logic              mem_we;
  logic [CODE_W-1:0] mem_rdata, mem_code, code;
  logic [POS_W-1:0]  pos_inc, eff_pos;
  logic              eff_mism;
  logic [OFFSET_W-1:0] eff_start;
  pat_view_t         pat;

  wsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pos_i       (pos_q[3:0]),
    .pat_o       (pat)
  );

  wsm_code_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_idx_q),
    .wdata_i (next_code_q),
    .re_i    (in_accept),
    .raddr_i (in_letter.idx),
    .rdata_o (mem_rdata)
  );

  // accept side
  assign in_letter  = letter_index(character_i);
  assign in_ready_o = !s1_valid_q || go;
  assign in_accept  = in_valid_i && in_ready_o;

  // resolve the byte in the input stage
  always_comb begin
    seen_hit  = seen_q[s1_idx_q];
    mem_code  = s1_fwd_q ? s1_fwd_code_q : mem_rdata;
    code      = seen_hit ? mem_code : next_code_q;
    in_range  = ({{(POS_W-PLEN_W){1'b0}}, pat.len} > pos_q) && (pos_q < PatMaxPos);
    bad       = !in_range || (code != pat.code);
    pos_inc   = (pos_q != POS_LIMIT) ? pos_q + 1'b1 : pos_q;
    eff_pos   = s1_letter_q ? pos_inc : pos_q;
    eff_mism  = s1_letter_q ? (mism_q | bad) : mism_q;
    eff_start = (s1_letter_q && !in_word_q) ? s1_off_q : start_q;
    close_w   = s1_letter_q ? s1_eoi_q : in_word_q;
    matched   = !eff_mism && (pat.len != '0) && (pat.len <= PatMaxLen) &&
                (eff_pos == {{(POS_W-PLEN_W){1'b0}}, pat.len});
    go        = s1_valid_q && (!close_w || !out_valid_q || out_ready_i);
    mem_we    = go && s1_letter_q && !seen_hit;
  end

  // word state next values
  always_comb begin
    seen_d      = seen_q;
    next_code_d = next_code_q;
    pos_d       = pos_q;
    mism_d      = mism_q;
    in_word_d   = in_word_q;
    start_d     = start_q;
    if (go) begin
      if (close_w) begin
        seen_d      = '0;
        next_code_d = CODE_FIRST;
        pos_d       = '0;
        mism_d      = 1'b0;
        in_word_d   = 1'b0;
      end else if (s1_letter_q) begin
        seen_d[s1_idx_q] = 1'b1;
        if (!seen_hit && next_code_q != CODE_LIMIT) begin
          next_code_d = next_code_q + 1'b1;
        end
        pos_d     = eff_pos;
        mism_d    = eff_mism;
        in_word_d = 1'b1;
      end
      start_d = eff_start;
    end
  end

  // stage and result valid flags
  always_comb begin
    s1_valid_d = in_accept ? 1'b1 : (go ? 1'b0 : s1_valid_q);
    if (go && close_w) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      next_code_q <= CODE_FIRST;
      pos_q       <= '0;
      mism_q      <= 1'b0;
      in_word_q   <= 1'b0;
      start_q     <= '0;
      offset_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
      next_code_q <= next_code_d;
      pos_q       <= pos_d;
      mism_q      <= mism_d;
      in_word_q   <= in_word_d;
      start_q     <= start_d;
      if (in_accept) begin
        offset_q <= offset_q + 1'b1;
      end
    end
  end

  // input stage payload, with forwarding of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_letter_q   <= in_letter.is_letter;
      s1_idx_q      <= in_letter.idx;
      s1_eoi_q      <= end_of_input_i;
      s1_off_q      <= offset_q;
      s1_fwd_q      <= mem_we && (s1_idx_q == in_letter.idx);
      s1_fwd_code_q <= next_code_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (go && close_w) begin
      out_matched_q <= matched;
      out_start_q   <= eff_start;
      out_len_q     <= eff_pos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_matched_q;
  assign word_start_o  = out_start_q;
  assign word_length_o = out_len_q;

`ifndef SYNTHESIS
  // outside a word the per-word state sits at its cleared values
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_word_q |-> (pos_q == '0 && next_code_q == CODE_FIRST && !mism_q && seen_q == '0))
    else $error("word state not cleared outside a word");

  // an open word has at least one letter
  a_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word_q |-> (pos_q != '0 && seen_q != '0))
    else $error("open word without letters");

  // codes handed out track the distinct letters seen
  a_code_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_code_q != CODE_LIMIT) |-> ($countones(seen_q) == int'(next_code_q) - 1))
    else $error("next code out of step with seen letters");
`endif

endmodule

// ----- bench/tb_word_shape_matcher.sv -----
// Self-checking bench for word_shape_matcher: byte stream in, one item per closed word out.
// Keeps its own model of the word and pattern state and checks every output item.
// Depends on wsm_pkg and word_shape_matcher.
module tb_word_shape_matcher
  import wsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned LONG_STALL      = 300;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // canonical shape 1, 2, ..., 16
  localparam logic [CODES_W-1:0] CANON_LO =
    {5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
  localparam logic [CODES_W-1:0] CANON_HI =
    {5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9};

  typedef struct packed {
    logic                matched;
    logic [OFFSET_W-1:0] first_offset;
    logic [POS_W-1:0]    word_len;
  } word_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CODES_W-1:0]   cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           character_i;
  logic                 end_of_input_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 matched_o;
  logic [OFFSET_W-1:0]  word_start_o;
  logic [POS_W-1:0]     word_length_o;

  // bench copy of the configuration
  logic [PLEN_W-1:0]  pat_len;
  logic [CODES_W-1:0] codes_lo;
  logic [CODES_W-1:0] codes_hi;

  // bench copy of the word state
  logic [CODE_W-1:0]       code_of [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] seen_mask;
  logic [CODE_W-1:0]       next_code;
  logic [POS_W-1:0]        word_letters;
  logic                    word_broken;
  logic                    open_word;
  logic [OFFSET_W-1:0]     stream_pos;
  logic [OFFSET_W-1:0]     word_first;

  word_result_t pending_words[$];

  int in_gap_pct;
  int out_stall_pct;
  int stalls_asked;
  int stalls_served;
  int bytes_sent;
  int mismatch_count;
  int cycle_count;

  word_shape_matcher uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .matched_o      (matched_o),
    .word_start_o   (word_start_o),
    .word_length_o  (word_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  // letter slot: a-z are 0..25, A-Z are 26..51, anything else -1
  function automatic int letter_slot(input logic [7:0] ch);
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return int'(ch - CH_LOWER_A);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch - CH_UPPER_A) + 26;
    return -1;
  endfunction

  function automatic logic [7:0] letter_char(input int slot);
    return (slot < 26) ? 8'(CH_LOWER_A + slot) : 8'(CH_UPPER_A + slot - 26);
  endfunction

  function automatic logic [CODE_W-1:0] pattern_code(input int pos);
    logic [CODES_W-1:0] half;
    half = (pos < 8) ? codes_lo : codes_hi;
    return half[CODE_W*(pos%8) +: CODE_W];
  endfunction

  task automatic clear_word_state();
    foreach (code_of[i]) code_of[i] = '0;
    seen_mask    = '0;
    next_code    = CODE_FIRST;
    word_letters = '0;
    word_broken  = 1'b0;
    open_word    = 1'b0;
  endtask

  task automatic close_open_word();
    word_result_t r;
    r.matched = !word_broken && pat_len != 0 && pat_len <= PATTERN_MAX_DEF &&
                word_letters == POS_W'(pat_len);
    r.first_offset = word_first;
    r.word_len     = word_letters;
    pending_words.push_back(r);
    clear_word_state();
  endtask

  // advance the word state by one accepted byte
  task automatic advance_word_state(input logic [7:0] ch, input logic eoi);
    int slot;
    logic [CODE_W-1:0] code;
    slot = letter_slot(ch);
    if (slot >= 0) begin
      if (!open_word) begin
        open_word  = 1'b1;
        word_first = stream_pos;
      end
      if (!seen_mask[slot]) begin
        seen_mask[slot] = 1'b1;
        code_of[slot]   = next_code;
        if (next_code < CODE_LIMIT) next_code = next_code + 1'b1;
      end
      code = code_of[slot];
      if (word_letters < POS_W'(pat_len) && word_letters < PATTERN_MAX_DEF) begin
        if (code != pattern_code(int'(word_letters))) word_broken = 1'b1;
      end else begin
        word_broken = 1'b1;
      end
      if (word_letters != POS_LIMIT) word_letters = word_letters + 1'b1;
      if (eoi) close_open_word();
    end else if (open_word) begin
      close_open_word();
    end
    stream_pos = stream_pos + 1'b1;
  endtask

  // ---------------------------------------------------------------- drivers

  // register write; valid stays up so back-to-back writes need no gap
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CODES_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LENGTH: pat_len  = data[PLEN_W-1:0];
      CFG_CODES_LOW:      codes_lo = data;
      CFG_CODES_HIGH:     codes_hi = data;
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [PLEN_W-1:0] len, input logic [CODES_W-1:0] lo,
                              input logic [CODES_W-1:0] hi, input logic poke_unused);
    write_cfg(CFG_PATTERN_LENGTH, CODES_W'(len));
    write_cfg(CFG_CODES_LOW, lo);
    write_cfg(CFG_CODES_HIGH, hi);
    // a write to the spare index must leave the pattern alone
    if (poke_unused) write_cfg(CFG_UNUSED, CODES_W'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  // offer one byte; valid is only dropped when an idle gap is taken
  task automatic send_byte(input logic [7:0] ch, input logic eoi);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    character_i    <= ch;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_word_state(ch, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(input string text, input logic eoi_last);
    for (int i = 0; i < text.len(); i++) send_byte(text[i], eoi_last && i == text.len() - 1);
  endtask

  // stop offering, wait for every expected item, then let the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] ch;
    ch = 8'($urandom);
    while (letter_slot(ch) >= 0) ch = 8'($urandom);
    return ch;
  endfunction

  // close a word either by end of input on its last letter or by a separator
  task automatic finish_word(input logic [7:0] last_letter);
    if ($urandom_range(4) == 0) begin
      send_byte(last_letter, 1'b1);
    end else begin
      send_byte(last_letter, 1'b0);
      send_byte(pick_separator(), $urandom_range(7) == 0);
    end
  endtask

  // random canonical shape; codes past the length are garbage
  task automatic load_random_shape(input int len);
    logic [2*CODES_W-1:0] codes;
    int used;
    int c;
    codes = '0;
    used  = 0;
    for (int p = 0; p < PATTERN_MAX_DEF; p++) begin
      if (p >= len) begin
        c = $urandom_range(31);
      end else if (used == 0 || (used < PATTERN_MAX_DEF && $urandom_range(1) == 0)) begin
        used++;
        c = used;
      end else begin
        c = $urandom_range(used, 1);
      end
      codes[CODE_W*p +: CODE_W] = CODE_W'(c);
    end
    load_pattern(PLEN_W'(len), codes[CODES_W-1:0], codes[2*CODES_W-1:CODES_W],
                 $urandom_range(3) == 0);
  endtask

  // word built on the current shape, sometimes one letter short, long or altered
  task automatic send_shaped_word();
    logic [7:0]        letter_for [32];
    logic [51:0]       taken;
    logic [CODE_W-1:0] code;
    logic [7:0]        ch;
    int slot;
    int n;
    int twist;
    taken = '0;
    for (int c = 0; c < 32; c++) begin
      slot = $urandom_range(51);
      while (taken[slot]) slot = $urandom_range(51);
      taken[slot]   = 1'b1;
      letter_for[c] = letter_char(slot);
    end
    n = (pat_len == 0 || pat_len > PATTERN_MAX_DEF) ? $urandom_range(16, 1) : int'(pat_len);
    twist = $urandom_range(9);
    if (twist == 0 && n > 1) n--;
    else if (twist == 1) n++;
    for (int p = 0; p < n; p++) begin
      code = (p < PATTERN_MAX_DEF) ? pattern_code(p) : CODE_W'($urandom_range(16, 1));
      ch   = letter_for[code];
      if (twist == 2 && p == n - 1) ch = letter_char($urandom_range(51));
      if (p == n - 1) finish_word(ch);
      else send_byte(ch, 1'b0);
    end
  endtask

  task automatic send_random_piece();
    logic [7:0] alpha [4];
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_shaped_word();
    end else if (pick < 80) begin
      // few distinct letters so repeats are common
      for (int k = 0; k < 4; k++) alpha[k] = letter_char($urandom_range(51));
      n = $urandom_range(20, 1);
      for (int k = 0; k < n - 1; k++) send_byte(alpha[$urandom_range(3)], 1'b0);
      finish_word(alpha[$urandom_range(3)]);
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  task automatic check_shape(input logic [PLEN_W-1:0] len, input logic [CODES_W-1:0] lo,
                             input logic [CODES_W-1:0] hi, input string text);
    load_pattern(len, lo, hi, 1'b0);
    send_text(text, 1'b1);
    drain_results();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_words();
    // pattern length is zero out of reset, so nothing matches
    send_text("ab", 1'b1);
    drain_results();
    load_pattern(4, {20'd0, 5'd1, 5'd3, 5'd2, 5'd1}, '0, 1'b0);
    send_text("zYaz", 1'b1);
    // bytes just outside the letter ranges, no word open
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("AazA{", 1'b0);
    send_text("abcab ", 1'b0);
    send_text("ZzZ@", 1'b1);
    drain_results();
  endtask

  task automatic test_pattern_limits();
    check_shape(0, {35'd0, 5'd1}, '0, "a b ");
    check_shape(16, CANON_LO, CANON_HI,
                "abcdefghijklmnop abcdefghijklmnopq abcdefghijklmnoa ");
    // more distinct letters than codes
    check_shape(16, CANON_LO, CANON_HI,
                "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ ");
    check_shape(17, CANON_LO, CANON_HI, "abcdefghijklmnop abcdefghijklmnopq ");
    check_shape(31, CANON_LO, CANON_HI, "abcdefghijklmnop abcdefghijklmnopq ");
    check_shape(2, {30'd0, 5'd1, 5'd0}, '0, "ab aa ");
    check_shape(1, {35'd0, 5'd17}, '0, "a ");
    // non-canonical order can never be produced
    check_shape(2, {30'd0, 5'd1, 5'd2}, '0, "ab ba ");
    check_shape(2, {30'd0, 5'd1, 5'd1}, '0, "aa aA ");
    check_shape(31, '1, '1, "xyz ");
    check_shape(0, '0, '0, "x ");
    load_pattern(2, {30'd0, 5'd2, 5'd1}, '0, 1'b1);
    send_text("ab ba aa ", 1'b1);
    drain_results();
  endtask

  task automatic test_random_stream(input int n);
    int stop_at;
    int group_end;
    int len_pick;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      len_pick = $urandom_range(99);
      if (len_pick < 6) load_random_shape(0);
      else if (len_pick < 12) load_random_shape($urandom_range(31, 17));
      else if (len_pick < 20) load_random_shape(PATTERN_MAX_DEF);
      else load_random_shape($urandom_range(8, 1));
      group_end = bytes_sent + $urandom_range(60, 20);
      while (bytes_sent < group_end && bytes_sent < stop_at) send_random_piece();
      send_byte(pick_separator(), 1'b1);
      drain_results();
    end
  endtask

  // output held off for a long stretch while short words keep coming
  task automatic test_output_backpressure();
    int saved_gap;
    saved_gap  = in_gap_pct;
    in_gap_pct = 0;
    load_pattern(1, {35'd0, 5'd1}, '0, 1'b0);
    stalls_asked++;
    repeat (40) begin
      send_byte(letter_char($urandom_range(51)), 1'b0);
      send_byte(pick_separator(), 1'b0);
    end
    in_gap_pct = saved_gap;
    drain_results();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_PATTERN_LENGTH;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    character_i    <= '0;
    end_of_input_i <= 1'b0;
    in_gap_pct     = 18;
    out_stall_pct  = 75;
    stalls_asked   = 0;
    bytes_sent     = 0;
    mismatch_count = 0;
    pat_len        = '0;
    codes_lo       = '0;
    codes_hi       = '0;
    stream_pos     = '0;
    word_first     = '0;
    clear_word_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_pattern_limits();
    test_random_stream(40);

    in_gap_pct    = 75;
    out_stall_pct = 18;
    test_random_stream(40);
    test_output_backpressure();

    in_gap_pct    = 0;
    out_stall_pct = 0;
    test_random_stream(40);

    if (mismatch_count == 0) begin
      $display("word_shape_matcher: match");
    end else begin
      $display("word_shape_matcher: mismatch");
    end
    $finish;
  end

  // output ready: random stalls, plus a long hold-off when a test asks for one
  initial begin : result_ready_drive
    int stall_left;
    stall_left    = 0;
    stalls_served = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_served != stalls_asked) begin
        stalls_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // compare each accepted item with the oldest pending word
  always @(posedge clk_i) begin : result_check
    word_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: matched=%0b start=%0d length=%0d",
                   matched_o, word_start_o, word_length_o);
      end else begin
        want = pending_words.pop_front();
        if (want.matched !== matched_o || want.first_offset !== word_start_o ||
            want.word_len !== word_length_o) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("item differs: expected matched=%0b start=%0d length=%0d, got %0b %0d %0d",
                     want.matched, want.first_offset, want.word_len,
                     matched_o, word_start_o, word_length_o);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("word_shape_matcher: mismatch");
    $finish;
  end

endmodule
